@@ hw/rtl/des_pkg.sv @@
// des_pkg: permutation tables, s-boxes and round functions of the des cipher
package des_pkg;

	localparam int unsigned ROUNDS = 16;

	typedef logic [47:0] round_key_t;
	typedef round_key_t round_keys_t [ROUNDS];

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	localparam byte unsigned T_IP [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam byte unsigned T_FP [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam byte unsigned T_E [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

	localparam byte unsigned T_P [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

	localparam byte unsigned T_PC1 [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

	localparam byte unsigned T_PC2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

	localparam byte unsigned T_ROT [ROUNDS] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] T_SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// bit numbering follows the standard: table entry 1 is the msb
	function automatic logic [63:0] perm_ip(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63 - i] = x[64 - int'(T_IP[i])];
		return y;
	endfunction

	function automatic logic [63:0] perm_fp(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) y[63 - i] = x[64 - int'(T_FP[i])];
		return y;
	endfunction

	function automatic logic [47:0] perm_e(input logic [31:0] x);
		logic [47:0] y;
		for (int i = 0; i < 48; i++) y[47 - i] = x[32 - int'(T_E[i])];
		return y;
	endfunction

	function automatic logic [31:0] perm_p(input logic [31:0] x);
		logic [31:0] y;
		for (int i = 0; i < 32; i++) y[31 - i] = x[32 - int'(T_P[i])];
		return y;
	endfunction

	function automatic logic [55:0] perm_pc1(input logic [63:0] x);
		logic [55:0] y;
		for (int i = 0; i < 56; i++) y[55 - i] = x[64 - int'(T_PC1[i])];
		return y;
	endfunction

	function automatic logic [47:0] perm_pc2(input logic [55:0] x);
		logic [47:0] y;
		for (int i = 0; i < 48; i++) y[47 - i] = x[56 - int'(T_PC2[i])];
		return y;
	endfunction

	function automatic logic [27:0] rot28(input logic [27:0] x, input byte unsigned s);
		return (s == 8'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
	endfunction

	// key schedule: pure wiring once the key is fixed
	function automatic round_keys_t make_round_keys(input logic [63:0] key);
		round_keys_t rk;
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		cd = perm_pc1(key);
		c = cd[55:28];
		d = cd[27:0];
		for (int n = 0; n < ROUNDS; n++) begin
			c = rot28(c, T_ROT[n]);
			d = rot28(d, T_ROT[n]);
			rk[n] = perm_pc2({c, d});
		end
		return rk;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input round_key_t k);
		logic [47:0] e;
		logic [5:0] six;
		logic [31:0] s;
		e = perm_e(r) ^ k;
		for (int b = 0; b < 8; b++) begin
			six = e[47 - 6*b -: 6];
			s[31 - 4*b -: 4] = T_SBOX[b][{six[5], six[0], six[4:1]}];
		end
		return perm_p(s);
	endfunction

endpackage

@@ hw/rtl/des_block_cipher.sv @@
// des_block_cipher: single-pass des ecb engine with apb key register
// Usage: load the 64-bit key (parity bits ignored) through the apb port at byte address 0,
// then raise start with req_type (0 encrypt, 1 decrypt) and data_block. busy never rises,
// so a new word is taken on every clock. The result passes the input and result registers
// to result_block, marked by a one-cycle done strobe; it cannot be held off, so
// the receiver must take it in that cycle. Throughput is one word per clock: all sixteen
// rounds sit in one combinational pass between the input register and the result
// register, so that pass sets the clock period. Change the key only with no word in flight.
module des_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [63:0] data_block,
	output logic        done,
	output logic [63:0] result_block
);
	import des_pkg::*;

	// key register and its schedule
	logic [63:0] key_q;
	round_keys_t rk;

	// input stage
	logic        vld_s1;
	op_t         op_s1;
	logic [63:0] blk_s1;

	// result stage
	logic        vld_s2;
	logic [63:0] res_s2;

	logic [63:0] res_d;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = key_q;
	assign cfg_wr = psel & penable & pwrite & (paddr == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr) begin
			key_q <= pwdata;
		end
	end

	assign rk = make_round_keys(key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
		end
	end

	// payload registers need no reset
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= op_t'(req_type);
			blk_s1 <= data_block;
		end
		if (vld_s1) begin
			res_s2 <= res_d;
		end
	end

	// ip, sixteen feistel rounds, swap and inverse ip
	always_comb begin
		logic [63:0] x;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		x = perm_ip(blk_s1);
		l = x[63:32];
		r = x[31:0];
		for (int n = 0; n < ROUNDS; n++) begin
			t = r;
			r = l ^ feistel(r, (op_s1 == OP_DECRYPT) ? rk[ROUNDS - 1 - n] : rk[n]);
			l = t;
		end
		res_d = perm_fp({r, l});
	end

	assign done         = vld_s2;
	assign result_block = res_s2;

	// a word in leads to exactly one done strobe, after the input and result registers
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("missing done after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start, 2)) else $error("done without start");

	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(key_q)) else $error("key changed");

endmodule

@@ tb/des_block_cipher_test.sv @@
// des_block_cipher_test: self-checking testbench for the des ecb engine
module des_block_cipher_test;
	import des_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// idle clocks added by drain once no word is left in flight, as margin
	localparam int DRAIN_CYCLES = 6;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [63:0] data_block;
	logic        done;
	logic [63:0] result_block;

	// model copy of the key register and the words still in flight
	logic [63:0] model_key;
	logic [63:0] pending_blocks [$];
	int          error_count;
	int          cycle_count;
	bit          no_gaps;

	des_block_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req_type(req_type), .data_block(data_block),
		.done(done), .result_block(result_block)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// key schedule: pc-1, per-round rotation of both halves, pc-2
	function automatic round_keys_t schedule_keys(input logic [63:0] key);
		round_keys_t rk;
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		int s;
		for (int i = 0; i < 56; i++) cd[55 - i] = key[64 - int'(T_PC1[i])];
		c = cd[55:28];
		d = cd[27:0];
		for (int n = 0; n < ROUNDS; n++) begin
			s = T_ROT[n];
			c = (c << s) | (c >> (28 - s));
			d = (d << s) | (d >> (28 - s));
			cd = {c, d};
			for (int i = 0; i < 48; i++) rk[n][47 - i] = cd[56 - int'(T_PC2[i])];
		end
		return rk;
	endfunction

	function automatic logic [63:0] des_transform(input logic [63:0] key, input op_t op,
			input logic [63:0] blk);
		round_keys_t rk;
		logic [63:0] x;
		logic [63:0] y;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		logic [31:0] sb;
		logic [31:0] f;
		logic [47:0] e;
		logic [5:0]  six;
		rk = schedule_keys(key);
		for (int i = 0; i < 64; i++) x[63 - i] = blk[64 - int'(T_IP[i])];
		l = x[63:32];
		r = x[31:0];
		for (int n = 0; n < ROUNDS; n++) begin
			for (int i = 0; i < 48; i++) e[47 - i] = r[32 - int'(T_E[i])];
			e ^= (op == OP_DECRYPT) ? rk[ROUNDS - 1 - n] : rk[n];
			for (int b = 0; b < 8; b++) begin
				six = e[47 - 6*b -: 6];
				sb[31 - 4*b -: 4] = T_SBOX[b][{six[5], six[0]} * 16 + six[4:1]];
			end
			for (int i = 0; i < 32; i++) f[31 - i] = sb[32 - int'(T_P[i])];
			t = r;
			r = l ^ f;
			l = t;
		end
		x = {r, l};
		for (int i = 0; i < 64; i++) y[63 - i] = x[64 - int'(T_FP[i])];
		return y;
	endfunction

	// every done strobe carries one word; compare with the oldest one in flight
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t unexpected word: expected none, actual %h", $time, result_block);
				error_count++;
			end else begin
				if (result_block !== pending_blocks[0]) begin
					$display("%0t result_block mismatch: expected %h, actual %h",
						$time, pending_blocks[0], result_block);
					error_count++;
				end
				void'(pending_blocks.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one word, each cycle idle with some chance unless gaps are off
	task automatic send_word(input op_t op, input logic [63:0] blk);
		if (!no_gaps) begin
			while ($urandom_range(99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req_type <= op;
		data_block <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_blocks.push_back(des_transform(model_key, op, blk));
	endtask

	// hold off until every word in flight has come back
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write of the key register, only with the engine idle
	task automatic load_key(input logic [63:0] key);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= key;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_key = key;
	endtask

	function automatic logic [63:0] rand_word;
		return {$urandom, $urandom};
	endfunction

	function automatic op_t rand_op;
		return op_t'($urandom_range(1));
	endfunction

	// zero key after reset, extreme blocks
	task automatic test_reset_key;
		send_word(OP_ENCRYPT, 64'h0);
		send_word(OP_DECRYPT, 64'h0);
		send_word(OP_ENCRYPT, '1);
		send_word(OP_DECRYPT, '1);
	endtask

	// textbook vector, both directions, and extreme keys
	task automatic test_known_vectors;
		load_key(64'h1334_5779_9BBC_DFF1);
		send_word(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
		send_word(OP_DECRYPT, 64'h85E8_1354_0F0A_B405);
		send_word(OP_ENCRYPT, 64'h8000_0000_0000_0001);
		load_key('1);
		send_word(OP_ENCRYPT, 64'h0);
		send_word(OP_DECRYPT, '1);
		load_key(64'h0101_0101_0101_0101);
		send_word(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
		send_word(OP_DECRYPT, 64'h0123_4567_89AB_CDEF);
	endtask

	// parity bits flipped must give the same words
	task automatic test_parity_ignored;
		load_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
		send_word(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
		send_word(OP_DECRYPT, 64'h85E8_1354_0F0A_B405);
		load_key(64'hFEFE_FEFE_FEFE_FEFE);
		send_word(OP_ENCRYPT, 64'h5555_AAAA_5555_AAAA);
		send_word(OP_DECRYPT, 64'hAAAA_5555_AAAA_5555);
	endtask

	// random words over several random keys, one back-to-back stretch
	task automatic test_random_traffic;
		for (int phase = 0; phase < 7; phase++) begin
			load_key(rand_word());
			no_gaps = (phase == 3);
			repeat (150) send_word(rand_op(), rand_word());
		end
		no_gaps = 1'b0;
	endtask

	// round trip: decrypt what was just encrypted under the same key
	task automatic test_round_trip;
		logic [63:0] ct;
		load_key(rand_word());
		repeat (20) begin
			ct = des_transform(model_key, OP_ENCRYPT, rand_word());
			send_word(OP_DECRYPT, ct);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = 1'b0;
		data_block = '0;
		model_key = '0;
		error_count = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_known_vectors();
		test_parity_ignored();
		test_random_traffic();
		test_round_trip();
		drain();
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
